FILE: design/ddn_ip_x25_address_map_unit_macros.svh
// Assertion macros shared by the address map design files.
// Both macros sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef DDN_IP_X25_ADDRESS_MAP_UNIT_MACROS_SVH
`define DDN_IP_X25_ADDRESS_MAP_UNIT_MACROS_SVH

// The property must hold at every enabled clock edge.
`define DIX_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The condition must never be true at an enabled clock edge.
`define DIX_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: design/dix25am_pkg.sv
package dix25am_pkg;

    // Command selector carried on the input tuser.
    localparam logic CMD_ENCODE = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    // Flag digit codes.
    localparam logic [3:0] MODE_PHYSICAL = 4'd0;
    localparam logic [3:0] MODE_LOGICAL  = 4'd1;

    // Network class of an IP address.
    typedef enum logic [1:0] {
        NET_CLASS_A,
        NET_CLASS_B,
        NET_CLASS_C
    } net_class_t;

    // Three BCD digits of an 8-bit value, hundreds in the top nibble.
    typedef logic [11:0] bcd3_t;
    typedef bcd3_t bcd3_tab_t [256];

    // Five BCD digits of a 16-bit value, ten-thousands in the top nibble.
    typedef logic [19:0] bcd5_t;
    typedef bcd5_t bcd5_tab_t [256];

    // Classify an address from its network byte.
    function automatic net_class_t get_net_class(input logic [7:0] net);
        net_class_t cls;
        if (!net[7])
        begin
            cls = NET_CLASS_A;
        end
        else if (net[7:6] == 2'b10)
        begin
            cls = NET_CLASS_B;
        end
        else
        begin
            cls = NET_CLASS_C;
        end
        return cls;
    endfunction

    // Built at elaboration: decimal digits of 0 to 255.
    function automatic bcd3_tab_t make_bcd3_tab();
        bcd3_tab_t tab;
        for (int i = 0; i < 256; i++)
        begin
            tab[i] = {4'(i / 100), 4'((i / 10) % 10), 4'(i % 10)};
        end
        return tab;
    endfunction

    // Built at elaboration: decimal digits of the port value times 256.
    function automatic bcd5_tab_t make_bcd5_tab();
        bcd5_tab_t tab;
        int        v;
        for (int i = 0; i < 256; i++)
        begin
            v      = i * 256;
            tab[i] = {4'(v / 10000), 4'((v / 1000) % 10), 4'((v / 100) % 10),
                      4'((v / 10) % 10), 4'(v % 10)};
        end
        return tab;
    endfunction

    localparam bcd3_tab_t BCD3_TAB = make_bcd3_tab();
    localparam bcd5_tab_t BCD5_TAB = make_bcd5_tab();

endpackage

FILE: design/ddn_ip_x25_address_map_unit.sv
// DDN address mapper between IP addresses and X.25 flag and address digits. Each input
// transfer carries a command on s_axis_tuser (encode or decode); one result transfer follows
// for each input, in order. The unit takes one transfer per clock while the result side does
// not stall. A result passes through the input register and then the result register, with
// the conversion done by table lookups and short adders between them. Stalls on the result
// side hold both registers and drop s_axis_tready once the input register is occupied.
// local_ip_wdata sets the local address used by decode; write it only while no transfer is
// in flight.
`include "ddn_ip_x25_address_map_unit_macros.svh"

module ddn_ip_x25_address_map_unit
    import dix25am_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Local address register write port.
    input  logic        local_ip_we,
    input  logic [31:0] local_ip_wdata,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // dest_ip[31:0], in_mode[35:32], in_digit_a[39:36], in_digit_b[43:40],
    // in_digit_c[47:44], in_digit_d[51:48], in_digit_e[55:52]
    input  logic [55:0] s_axis_tdata,
    // command[0]
    input  logic        s_axis_tuser,
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // ip_result[31:0], out_mode[32], out_digit_a[36:33], out_digit_b[40:37],
    // out_digit_c[44:41], out_digit_d[48:45], out_digit_e[52:49], zero[55:53]
    output logic [55:0] m_axis_tdata,
    // addr_ok[0]
    output logic        m_axis_tuser
);

    logic        local_ip_reg;
    logic [31:0] local_ip_addr_reg;

    logic        in_valid_reg;
    logic        in_cmd_reg;
    logic [55:0] in_data_reg;

    logic        res_valid_reg;
    logic        res_ok_reg;
    logic [31:0] res_ip_reg;
    logic        res_mode_reg;
    logic [19:0] res_dig_reg;

    logic        res_ok_next;
    logic [31:0] res_ip_next;
    logic        res_mode_next;
    logic [19:0] res_dig_next;

    logic        advance;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_ip_reg      <= 1'b0;
            local_ip_addr_reg <= 32'd0;
        end
        else if (local_ip_we)
        begin
            local_ip_reg      <= 1'b1;
            local_ip_addr_reg <= local_ip_wdata;
        end
    end

    // The result register moves when it is empty or its transfer completes.
    assign advance       = !res_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_cmd_reg  <= s_axis_tuser;
            in_data_reg <= s_axis_tdata;
        end
    end

    // Conversion logic between the input and result registers.
    always_comb
    begin
        logic [31:0] ip;
        logic [3:0]  mode;
        logic [3:0]  da, db, dc, dd, de;
        net_class_t  enc_cls;
        net_class_t  loc_cls;
        logic [7:0]  imp_no;
        logic [7:0]  enc_port;
        bcd3_t       imp_bcd;
        bcd3_t       port_bcd;
        bcd5_t       hi_bcd;
        logic [4:0]  dsum;
        logic        carry;
        logic [19:0] sum_bcd;
        logic [10:0] dec_imp0;
        logic [7:0]  dec_port0;
        logic [17:0] dec_t;
        logic [7:0]  dec_imp;
        logic [7:0]  dec_port;
        logic [7:0]  c_byte;

        ip   = in_data_reg[31:0];
        mode = in_data_reg[35:32];
        da   = in_data_reg[39:36];
        db   = in_data_reg[43:40];
        dc   = in_data_reg[47:44];
        dd   = in_data_reg[51:48];
        de   = in_data_reg[55:52];

        // Encode: pick IMP number and port by class.
        enc_cls = get_net_class(ip[31:24]);
        case (enc_cls)
            NET_CLASS_A:
            begin
                imp_no   = ip[7:0];
                enc_port = ip[23:16];
            end
            NET_CLASS_B:
            begin
                imp_no   = ip[7:0];
                enc_port = ip[15:8];
            end
            default:
            begin
                imp_no   = {5'd0, ip[7:5]};
                enc_port = {3'd0, ip[4:0]};
            end
        endcase

        imp_bcd  = BCD3_TAB[imp_no];
        port_bcd = BCD3_TAB[enc_port];
        hi_bcd   = BCD5_TAB[enc_port];

        // Logical form: BCD sum of port*256 and the IMP number.
        carry   = 1'b0;
        sum_bcd = '0;
        for (int i = 0; i < 5; i++)
        begin
            if (i < 3)
            begin
                dsum = {1'b0, hi_bcd[i*4 +: 4]} + {1'b0, imp_bcd[i*4 +: 4]} + {4'd0, carry};
            end
            else
            begin
                dsum = {1'b0, hi_bcd[i*4 +: 4]} + {4'd0, carry};
            end
            if (dsum > 5'd9)
            begin
                dsum  = dsum - 5'd10;
                carry = 1'b1;
            end
            else
            begin
                carry = 1'b0;
            end
            sum_bcd[i*4 +: 4] = dsum[3:0];
        end

        // Decode: rebuild IMP number and port, low bytes only matter.
        dec_imp0  = 11'(da) * 11'd100 + 11'(db) * 11'd10 + 11'(dc);
        dec_port0 = 8'(dd) * 8'd10 + 8'(de);
        dec_t     = 18'(da) * 18'd10000 + 18'(db) * 18'd1000 + 18'(dc) * 18'd100
                  + 18'(dd) * 18'd10 + 18'(de);
        if (mode == MODE_PHYSICAL)
        begin
            dec_imp  = dec_imp0[7:0];
            dec_port = dec_port0;
        end
        else
        begin
            dec_imp  = dec_t[7:0];
            dec_port = dec_t[15:8];
        end
        c_byte  = {dec_imp[2:0], 5'd0} + dec_port;
        loc_cls = get_net_class(local_ip_addr_reg[31:24]);

        res_ok_next   = 1'b1;
        res_ip_next   = 32'd0;
        res_mode_next = 1'b0;
        res_dig_next  = 20'd0;

        if (in_cmd_reg == CMD_ENCODE)
        begin
            if (enc_port[7:6] == 2'b00)
            begin
                res_dig_next = {imp_bcd, port_bcd[7:0]};
            end
            else
            begin
                res_mode_next = 1'b1;
                res_dig_next  = sum_bcd;
            end
        end
        else if (mode == MODE_PHYSICAL || mode == MODE_LOGICAL)
        begin
            case (loc_cls)
                NET_CLASS_A:
                    res_ip_next = {local_ip_addr_reg[31:24], dec_port, 8'd0, dec_imp};
                NET_CLASS_B:
                    res_ip_next = {local_ip_addr_reg[31:16], dec_port, dec_imp};
                default:
                    res_ip_next = {local_ip_addr_reg[31:8], c_byte};
            endcase
        end
        else
        begin
            res_ok_next = 1'b0;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            res_ok_reg   <= res_ok_next;
            res_ip_reg   <= res_ip_next;
            res_mode_reg <= res_mode_next;
            res_dig_reg  <= res_dig_next;
        end
    end

    // Output packing; the digit register holds digit a in its top nibble.
    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tuser  = res_ok_reg;
    assign m_axis_tdata  = {3'd0, res_dig_reg[3:0], res_dig_reg[7:4], res_dig_reg[11:8],
                            res_dig_reg[15:12], res_dig_reg[19:16], res_mode_reg,
                            res_ip_reg};

    // Checks on the pipeline and the conversion.
    `DIX_ASSERT(a_in_hold, (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_data_reg)), "input register changed while stalled")
    `DIX_ASSERT(a_ready_when_empty, (!in_valid_reg) |-> s_axis_tready, "input not ready with empty stage")
    `DIX_ASSERT_NEVER(a_bad_nonzero, m_axis_tvalid && !m_axis_tuser && (m_axis_tdata != 56'd0), "invalid result carries data")
    `DIX_ASSERT(a_enc_digits, (advance && in_valid_reg && in_cmd_reg == CMD_ENCODE) |=> (res_ok_reg && res_ip_reg == 32'd0 && res_dig_reg[19:16] <= 4'd9 && res_dig_reg[15:12] <= 4'd9 && res_dig_reg[11:8] <= 4'd9 && res_dig_reg[7:4] <= 4'd9 && res_dig_reg[3:0] <= 4'd9), "encode result out of range")
    `DIX_ASSERT(a_dec_flag, (advance && in_valid_reg && in_cmd_reg == CMD_DECODE) |=> (res_ok_reg == ($past(in_data_reg[35:32]) == MODE_PHYSICAL || $past(in_data_reg[35:32]) == MODE_LOGICAL)), "decode flag check wrong")
    `DIX_ASSERT(a_cfg_seen, (local_ip_reg == 1'b0) |-> (local_ip_addr_reg == 32'd0), "local address changed without a write")

endmodule

FILE: sim/ddn_ip_x25_address_map_checker.sv
`timescale 1ns / 100ps

// Watches both streams and the local address write port of the address map unit.
// It predicts each result when its input transfer is accepted and compares every
// result transfer with the oldest prediction.
module ddn_ip_x25_address_map_checker
    import dix25am_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        local_ip_we,
    input  logic [31:0] local_ip_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [55:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    output int          mismatch_count,
    output int          maps_in_flight
);

    // One converted address as it should leave the unit.
    typedef struct packed {
        logic        addr_ok;
        logic [31:0] ip_result;
        logic        out_mode;
        logic [3:0]  digit_a;
        logic [3:0]  digit_b;
        logic [3:0]  digit_c;
        logic [3:0]  digit_d;
        logic [3:0]  digit_e;
    } addr_map_t;

    addr_map_t   pending_maps[$];
    logic [31:0] own_ip;

    initial
    begin
        mismatch_count = 0;
        maps_in_flight = 0;
        own_ip         = '0;
    end

    // Network class from the leading bits of an address.
    function automatic net_class_t class_of(input logic [31:0] ip);
        net_class_t cls;
        if (ip[31] == 1'b0)
        begin
            cls = NET_CLASS_A;
        end
        else if (ip[30] == 1'b0)
        begin
            cls = NET_CLASS_B;
        end
        else
        begin
            cls = NET_CLASS_C;
        end
        return cls;
    endfunction

    // Expected conversion of one input transfer under the given local address.
    function automatic addr_map_t map_address(input logic cmd, input logic [55:0] data,
                                              input logic [31:0] local_ip);
        addr_map_t   res;
        logic [31:0] ip;
        logic [3:0]  mode;
        int unsigned imp_no;
        int unsigned port_no;
        int unsigned t;
        res = '0;
        if (cmd == CMD_ENCODE)
        begin
            ip = data[31:0];
            case (class_of(ip))
                NET_CLASS_A:
                begin
                    imp_no  = ip[7:0];
                    port_no = ip[23:16];
                end
                NET_CLASS_B:
                begin
                    imp_no  = ip[7:0];
                    port_no = ip[15:8];
                end
                default:
                begin
                    imp_no  = ip[7:0] / 32;
                    port_no = ip[7:0] % 32;
                end
            endcase
            res.addr_ok = 1'b1;
            if (port_no < 64)
            begin
                // Physical form: three digits of the IMP number, two of the port.
                res.out_mode = MODE_PHYSICAL[0];
                res.digit_a  = 4'(imp_no / 100);
                res.digit_b  = 4'((imp_no % 100) / 10);
                res.digit_c  = 4'(imp_no % 10);
                res.digit_d  = 4'(port_no / 10);
                res.digit_e  = 4'(port_no % 10);
            end
            else
            begin
                // Logical form: five digits of port * 256 + IMP number.
                t            = port_no * 256 + imp_no;
                res.out_mode = MODE_LOGICAL[0];
                res.digit_a  = 4'(t / 10000);
                res.digit_b  = 4'((t % 10000) / 1000);
                res.digit_c  = 4'((t % 1000) / 100);
                res.digit_d  = 4'((t % 100) / 10);
                res.digit_e  = 4'(t % 10);
            end
        end
        else
        begin
            mode = data[35:32];
            if (mode == MODE_PHYSICAL)
            begin
                imp_no  = data[39:36] * 100 + data[43:40] * 10 + data[47:44];
                port_no = data[51:48] * 10 + data[55:52];
            end
            else if (mode == MODE_LOGICAL)
            begin
                t = data[39:36] * 10000 + data[43:40] * 1000 + data[47:44] * 100
                    + data[51:48] * 10 + data[55:52];
                port_no = t >> 8;
                imp_no  = t & 32'hff;
            end
            else
            begin
                // A bad flag nibble gives an all-zero result with addr_ok low.
                return res;
            end
            res.addr_ok = 1'b1;
            case (class_of(local_ip))
                NET_CLASS_A:
                begin
                    res.ip_result = {local_ip[31:24], 8'(port_no), 8'h00, 8'(imp_no)};
                end
                NET_CLASS_B:
                begin
                    res.ip_result = {local_ip[31:16], 8'(port_no), 8'(imp_no)};
                end
                default:
                begin
                    res.ip_result = {local_ip[31:8], 8'((imp_no << 5) + port_no)};
                end
            endcase
        end
        return res;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Compare one result transfer, field by field, with the oldest prediction.
    task automatic check_result();
        addr_map_t want;
        if (pending_maps.size() == 0)
        begin
            mismatch_count++;
            $display("%0t: result transfer with none expected, expected none, actual %0h/%0h",
                     $time, m_axis_tuser, m_axis_tdata);
            return;
        end
        want = pending_maps.pop_front();
        compare_field("addr_ok", want.addr_ok, m_axis_tuser);
        compare_field("ip_result", want.ip_result, m_axis_tdata[31:0]);
        compare_field("out_mode", want.out_mode, m_axis_tdata[32]);
        compare_field("out_digit_a", want.digit_a, m_axis_tdata[36:33]);
        compare_field("out_digit_b", want.digit_b, m_axis_tdata[40:37]);
        compare_field("out_digit_c", want.digit_c, m_axis_tdata[44:41]);
        compare_field("out_digit_d", want.digit_d, m_axis_tdata[48:45]);
        compare_field("out_digit_e", want.digit_e, m_axis_tdata[52:49]);
        compare_field("tdata padding", 32'd0, m_axis_tdata[55:53]);
    endtask

    // Results are checked before new predictions are queued; the latency keeps them apart.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip = '0;
            pending_maps.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_result();
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                pending_maps.push_back(map_address(s_axis_tuser, s_axis_tdata, own_ip));
            end
            if (local_ip_we)
            begin
                own_ip = local_ip_wdata;
            end
        end
        maps_in_flight = pending_maps.size();
    end

endmodule

FILE: sim/tb_ddn_ip_x25_address_map_unit.sv
`timescale 1ns / 100ps

module tb_ddn_ip_x25_address_map_unit;
    import dix25am_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        local_ip_we;
    logic [31:0] local_ip_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tuser;

    int mismatch_count;
    int maps_in_flight;

    // Stimulus controls and tallies for the summary.
    bit sender_idles;
    bit receiver_idles;
    int hold_requests;
    int n_encode;
    int n_decode;
    int n_bad_flag;
    int n_settings;

    ddn_ip_x25_address_map_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .local_ip_we    (local_ip_we),
        .local_ip_wdata (local_ip_wdata),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser)
    );

    ddn_ip_x25_address_map_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .local_ip_we    (local_ip_we),
        .local_ip_wdata (local_ip_wdata),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .mismatch_count (mismatch_count),
        .maps_in_flight (maps_in_flight)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Hard limit on the run, far above the slowest correct run.
    initial
    begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

    // Encode transfer: the digit nibbles are ignored, so they carry noise.
    function automatic logic [55:0] encode_word(input logic [31:0] ip);
        return {16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)), ip};
    endfunction

    // Decode transfer: the address field is ignored, so it carries noise.
    function automatic logic [55:0] decode_word(input logic [3:0] mode, input logic [3:0] a,
                                                input logic [3:0] b, input logic [3:0] c,
                                                input logic [3:0] d, input logic [3:0] e);
        return {e, d, c, b, a, mode, 32'($urandom)};
    endfunction

    // Mostly proper decimal digits, sometimes nibbles above nine.
    function automatic logic [3:0] pick_digit();
        if ($urandom_range(0, 9) < 7)
        begin
            return 4'($urandom_range(0, 9));
        end
        return 4'($urandom_range(0, 15));
    endfunction

    // Offer one transfer, with an optional idle burst in front. Returns at a falling edge
    // with tvalid still high, so back-to-back calls keep the stream full.
    task automatic send_item(input logic cmd, input logic [55:0] data);
        if (sender_idles && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        if (cmd == CMD_ENCODE)
        begin
            n_encode++;
        end
        else if (data[35:32] == MODE_PHYSICAL || data[35:32] == MODE_LOGICAL)
        begin
            n_decode++;
        end
        else
        begin
            n_bad_flag++;
        end
    endtask

    // Stop offering and wait until every predicted result has come out.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (maps_in_flight != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_local_ip(input logic [31:0] value);
        local_ip_we    <= 1'b1;
        local_ip_wdata <= value;
        @(negedge clk);
        local_ip_we    <= 1'b0;
        @(negedge clk);
        n_settings++;
    endtask

    // One phase of random transfers under a fixed local address.
    task automatic run_phase(input logic [31:0] local_ip, input int count, input bit idles,
                             input bit hold);
        logic [3:0] mode;
        drain();
        write_local_ip(local_ip);
        sender_idles   = idles;
        receiver_idles = idles;
        if (hold)
        begin
            hold_requests++;
        end
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                send_item(CMD_ENCODE, encode_word($urandom));
            end
            else
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    mode = 4'($urandom_range(0, 15));
                end
                else if ($urandom_range(0, 1) == 0)
                begin
                    mode = MODE_PHYSICAL;
                end
                else
                begin
                    mode = MODE_LOGICAL;
                end
                send_item(CMD_DECODE, decode_word(mode, pick_digit(), pick_digit(),
                                                  pick_digit(), pick_digit(), pick_digit()));
            end
        end
    endtask

    // Result side: random stall bursts, plus a long hold-off when one is requested.
    initial
    begin
        int stall_left;
        int holds_served;
        stall_left    = 0;
        holds_served  = 0;
        m_axis_tready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                stall_left   = 150;
            end
            else if (stall_left == 0 && receiver_idles && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 10);
            end
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
            @(negedge clk);
        end
    end

    // Reset, directed corner cases, then random phases over several local addresses.
    initial
    begin
        rst_n          = 1'b0;
        local_ip_we    = 1'b0;
        local_ip_wdata = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = CMD_ENCODE;
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        hold_requests  = 0;
        n_encode       = 0;
        n_decode       = 0;
        n_bad_flag     = 0;
        n_settings     = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Encode corners: each class, both flag forms, smallest and largest fields.
        send_item(CMD_ENCODE, encode_word(32'h0000_0000));
        send_item(CMD_ENCODE, encode_word(32'hFFFF_FFFF));
        send_item(CMD_ENCODE, encode_word(32'h0A3F_00FF));
        send_item(CMD_ENCODE, encode_word(32'h0A40_0001));
        send_item(CMD_ENCODE, encode_word(32'h7FFF_FFFF));
        send_item(CMD_ENCODE, encode_word(32'h8000_3F07));
        send_item(CMD_ENCODE, encode_word(32'h8000_4000));
        send_item(CMD_ENCODE, encode_word(32'hBFFF_FFFF));
        send_item(CMD_ENCODE, encode_word(32'hC000_0000));
        send_item(CMD_ENCODE, encode_word(32'hDEAD_BEEF));
        send_item(CMD_ENCODE, encode_word(32'hFFFF_FF1F));

        // Decode corners under the reset local address: both flags, digits above nine,
        // and flag nibbles that are neither physical nor logical.
        send_item(CMD_DECODE, decode_word(MODE_PHYSICAL, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0));
        send_item(CMD_DECODE, decode_word(MODE_PHYSICAL, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9));
        send_item(CMD_DECODE, decode_word(MODE_PHYSICAL, 4'd2, 4'd5, 4'd5, 4'd6, 4'd3));
        send_item(CMD_DECODE, decode_word(MODE_PHYSICAL, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15));
        send_item(CMD_DECODE, decode_word(MODE_LOGICAL, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0));
        send_item(CMD_DECODE, decode_word(MODE_LOGICAL, 4'd6, 4'd5, 4'd5, 4'd3, 4'd5));
        send_item(CMD_DECODE, decode_word(MODE_LOGICAL, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9));
        send_item(CMD_DECODE, decode_word(MODE_LOGICAL, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15));
        send_item(CMD_DECODE, decode_word(4'd2, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5));
        send_item(CMD_DECODE, decode_word(4'd8, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9));
        send_item(CMD_DECODE, decode_word(4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15));

        // Random phases; the long hold-off fills the unit while the sender keeps offering.
        run_phase(32'hFFFF_FFFF, 145, 1'b1, 1'b0);
        run_phase(32'h7FFF_FFFF, 145, 1'b0, 1'b1);
        run_phase(32'h8000_0000, 145, 1'b1, 1'b0);
        run_phase(32'hBFFF_FFFF, 145, 1'b1, 1'b0);
        run_phase(32'hC000_0000, 145, 1'b1, 1'b0);
        for (int i = 0; i < 3; i++)
        begin
            run_phase($urandom, 145, 1'b1, 1'b0);
        end
        run_phase(32'h0000_0000, 145, 1'b0, 1'b0);
        drain();

        $display("Covered %0d encode, %0d decode and %0d bad-flag transfers",
                 n_encode, n_decode, n_bad_flag);
        $display("under %0d local address settings plus the reset value; %0d mismatches",
                 n_settings, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/dix25am_pkg.sv
design/ddn_ip_x25_address_map_unit.sv
sim/ddn_ip_x25_address_map_checker.sv
sim/tb_ddn_ip_x25_address_map_unit.sv
